// File: rtl/core/slrg_pkg.sv
// ----------------------------------------------------------------------------
// slrg_pkg
// shared constants and controller/datapath interface types for the
// shuffled lehmer random generator
// ----------------------------------------------------------------------------
package slrg_pkg;

  localparam int unsigned VALUE_W = 31;
  localparam int unsigned MULT_W  = 15;
  localparam int unsigned PROD_W  = VALUE_W + MULT_W;

  // minimal-standard multiplier and mersenne modulus 2^31-1
  localparam logic [MULT_W-1:0]  LEHMER_MULT = 15'd16807;
  localparam logic [VALUE_W-1:0] LEHMER_MOD  = 31'h7FFF_FFFF;

  // warm-up steps beyond the table size during seeding
  localparam int unsigned WARMUP_EXTRA = 8;

  // controller to datapath commands
  typedef struct packed {
    logic accept;      // capture seed or keep state, load warm-up count
    logic mul;         // product <= lehmer * multiplier
    logic fold;        // lehmer <= product mod 2^31-1
    logic seed_write;  // write folded value into table during warm-up
    logic div_init;    // reciprocal estimate of the slot from shuffle output
    logic div_step;    // slot search step: back-multiply, then correction
    logic finish;      // swap table entry and load result register
  } slrg_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic reseed;      // accepted item needs a seeding pass
    logic cnt_zero;    // warm-up or slot search counter at zero
    logic out_free;    // result register can take a value this cycle
  } slrg_stat_t;

endpackage

// File: rtl/core/slrg_ram.sv
// ----------------------------------------------------------------------------
// slrg_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module slrg_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/slrg_datapath.sv
// ----------------------------------------------------------------------------
// slrg_datapath
// lehmer multiply and fold, slot search, shuffle table and result register
// ----------------------------------------------------------------------------
module slrg_datapath import slrg_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  slrg_cmd_t          cmd,
  output slrg_stat_t         stat,
  input  logic               command,
  input  logic [VALUE_W-1:0] seed_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VALUE_W-1:0] sample
);

  localparam int unsigned IDX_W    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned TOTAL    = TABLE_ENTRIES + WARMUP_EXTRA;
  localparam int unsigned CNT_W    = $clog2(TOTAL);
  localparam int unsigned SLOT_DIV = 1 + (2**VALUE_W - 2) / TABLE_ENTRIES;
  // floor(2^31 / SLOT_DIV), never above TABLE_ENTRIES
  localparam int unsigned SLOT_RECIP = 32'h8000_0000 / SLOT_DIV;
  localparam int unsigned RECIP_W    = IDX_W + 1;
  localparam int unsigned EST_W      = VALUE_W + RECIP_W;

  logic [VALUE_W-1:0] lehmer;
  logic [VALUE_W-1:0] shuffle_out;
  logic [PROD_W-1:0]  prod;
  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] rem;
  logic [VALUE_W-1:0] back;
  logic [IDX_W-1:0]   quot;

  logic [VALUE_W:0]   fold_sum;
  logic [VALUE_W-1:0] folded;
  logic               seed_bad;
  logic [VALUE_W-1:0] seed_clean;
  logic [EST_W-1:0]   est_prod;
  logic [IDX_W-1:0]   slot_est;
  logic [VALUE_W-1:0] rem_left;
  logic               slot_up;
  logic [IDX_W-1:0]   slot;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [VALUE_W-1:0] ram_rdata;

  // mersenne fold: hi + lo, then one conditional subtract
  assign fold_sum = {1'b0, prod[VALUE_W-1:0]} + (VALUE_W+1)'(prod[PROD_W-1:VALUE_W]);
  assign folded   = (fold_sum >= {1'b0, LEHMER_MOD})
                    ? VALUE_W'(fold_sum - {1'b0, LEHMER_MOD}) : fold_sum[VALUE_W-1:0];

  assign seed_bad   = (seed_value == '0) || (seed_value == LEHMER_MOD);
  assign seed_clean = seed_bad ? VALUE_W'(1) : seed_value;

  // reciprocal estimate is the exact slot or one below it
  assign est_prod = EST_W'(shuffle_out) * EST_W'(SLOT_RECIP);
  assign slot_est = est_prod[VALUE_W+IDX_W-1:VALUE_W];
  assign rem_left = rem - back;
  assign slot_up  = (rem_left >= VALUE_W'(SLOT_DIV));

  assign slot   = ({1'b0, quot} >= (IDX_W+1)'(TABLE_ENTRIES))
                  ? IDX_W'(TABLE_ENTRIES - 1) : quot;

  assign stat.reseed   = command || (shuffle_out == '0);
  assign stat.cnt_zero = (cnt == '0);
  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      lehmer      <= VALUE_W'(1);
      shuffle_out <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (command) begin
          lehmer <= seed_clean;
        end else if (shuffle_out == '0) begin
          lehmer <= VALUE_W'(1);
        end
      end
      if (cmd.fold) begin
        lehmer <= folded;
      end
      // last warm-up value is table entry zero and the new shuffle output
      if (cmd.seed_write && (cnt == '0)) begin
        shuffle_out <= folded;
      end
      if (cmd.finish) begin
        shuffle_out <= ram_rdata;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= PROD_W'(lehmer) * PROD_W'(LEHMER_MULT);
    end
    if (cmd.accept) begin
      cnt <= CNT_W'(TOTAL - 1);
    end else if (cmd.seed_write || cmd.div_step) begin
      cnt <= cnt - CNT_W'(1);
    end else if (cmd.div_init) begin
      cnt <= CNT_W'(1);
    end
    if (cmd.div_init) begin
      rem  <= shuffle_out;
      quot <= slot_est;
    end else if (cmd.div_step) begin
      if (cnt != '0) begin
        back <= VALUE_W'(quot) * VALUE_W'(SLOT_DIV);
      end else begin
        quot <= quot + IDX_W'(slot_up);
      end
    end
    if (cmd.finish) begin
      sample <= ram_rdata;
    end
  end

  assign ram_we    = (cmd.seed_write && ({1'b0, cnt} < (CNT_W+1)'(TABLE_ENTRIES)))
                     || cmd.finish;
  assign ram_waddr = cmd.finish ? slot : cnt[IDX_W-1:0];
  assign ram_wdata = cmd.finish ? lehmer : folded;

  slrg_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(slot),
    .rdata(ram_rdata)
  );

endmodule

// File: rtl/core/slrg_ctrl.sv
// ----------------------------------------------------------------------------
// slrg_ctrl
// sequencer for seeding warm-up, draw step, slot search and table swap
// ----------------------------------------------------------------------------
module slrg_ctrl import slrg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  slrg_stat_t stat,
  output slrg_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SEED_MUL  = 3'd1;
  localparam logic [2:0] S_SEED_FOLD = 3'd2;
  localparam logic [2:0] S_DRAW_MUL  = 3'd3;
  localparam logic [2:0] S_DRAW_FOLD = 3'd4;
  localparam logic [2:0] S_DIV       = 3'd5;
  localparam logic [2:0] S_RD_WAIT   = 3'd6;
  localparam logic [2:0] S_FINISH    = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = rst || (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && !rst) begin
          cmd.accept = 1'b1;
          state_next = stat.reseed ? S_SEED_MUL : S_DRAW_MUL;
        end
      end
      S_SEED_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SEED_FOLD;
      end
      S_SEED_FOLD: begin
        cmd.fold       = 1'b1;
        cmd.seed_write = 1'b1;
        state_next     = stat.cnt_zero ? S_DRAW_MUL : S_SEED_MUL;
      end
      S_DRAW_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DRAW_FOLD;
      end
      S_DRAW_FOLD: begin
        cmd.fold     = 1'b1;
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.cnt_zero) begin
          state_next = S_RD_WAIT;
        end
      end
      S_RD_WAIT: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/core/shuffled_lehmer_random_generator.sv
// ----------------------------------------------------------------------------
// shuffled_lehmer_random_generator
// minimal-standard lehmer generator with a bays-durham shuffle table
// ----------------------------------------------------------------------------
// each input transaction yields one sample: command 0 draws, command 1 reseeds
// with seed_value (0 or 2^31-1 become 1) and then draws; a draw before any
// seeding first seeds with 1. the uniform fraction is sample / (2^31-1).
// one item at a time: after acceptance a plain draw holds the input through
// the multiply/fold step, a slot search (reciprocal estimate, then one
// back-multiply and correction) and the registered table read before the
// swap; the swap waits while the previous sample still waits in the result
// register. seeding adds the warm-up steps through the same multiplier.
// the table is a ram with a registered read; the result register lets work
// go on while a sample waits.
// ----------------------------------------------------------------------------
module shuffled_lehmer_random_generator import slrg_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic               clk,
  input  logic               rst,
  // input transactions
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic [VALUE_W-1:0] seed_value,
  // result transactions
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VALUE_W-1:0] sample
);

  // command and status between sequencer and datapath
  slrg_cmd_t  cmd;
  slrg_stat_t stat;

  // sequencer: warm-up loop, draw, slot search, table swap
  slrg_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  // datapath: lehmer multiplier, shuffle table and result register
  slrg_datapath #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .command   (command),
    .seed_value(seed_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample    (sample)
  );

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the shuffled lehmer random generator
// ----------------------------------------------------------------------------
// a short table of directed draws and reseeds is followed by several hundred
// random commands. every accepted transaction runs through an in-bench
// predictor (lehmer step, bays-durham shuffle, seeding with warm-up), and
// each accepted sample is checked in order against the predicted value.
// both sides idle at random and the receiver holds off once for a long
// stretch so the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module tb_top import slrg_pkg::*; ();

  localparam int unsigned TABLE_N    = 32;
  localparam int unsigned WARMUP_N   = TABLE_N + WARMUP_EXTRA;
  // width of one table slot over the output range
  localparam int unsigned SLOT_SPAN  = 1 + (int'(LEHMER_MOD) - 1) / TABLE_N;

  localparam logic CMD_DRAW   = 1'b0;
  localparam logic CMD_RESEED = 1'b1;

  localparam int NO_TWIN        = -1;
  localparam int DIRECTED_N     = 24;
  localparam int RANDOM_N       = 630;
  localparam int PRESSURE_AT    = 230;  // result index where the long hold starts
  localparam int PRESSURE_HOLD  = 400;  // cycles of receiver hold-off
  localparam int DRAIN_CYCLES   = 120;  // longer than a seeding pass

  typedef struct packed {
    logic               cmd;
    logic [VALUE_W-1:0] seed;
    int                 twin;  // earlier row whose sample must repeat
  } stim_row_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    int                 row;   // directed row, or NO_TWIN for random items
  } sample_expect_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               command = CMD_DRAW;
  logic [VALUE_W-1:0] seed_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [VALUE_W-1:0] sample;

  // predictor state
  logic [VALUE_W-1:0] gen_state  = 31'd1;
  logic [VALUE_W-1:0] shuf_state = '0;   // zero means not seeded yet
  logic [VALUE_W-1:0] shuf_table [TABLE_N];

  stim_row_t          directed [DIRECTED_N];
  logic [VALUE_W-1:0] directed_seen [DIRECTED_N];
  sample_expect_t     expected_samples [$];
  int                 fail_count = 0;
  int                 items_sent = 0;

  shuffled_lehmer_random_generator #(
    .TABLE_ENTRIES (TABLE_N)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .seed_value (seed_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample     (sample)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // one minimal-standard step, exact modulo 2^31-1
  function automatic logic [VALUE_W-1:0] lehmer_advance(input logic [VALUE_W-1:0] x);
    logic [63:0] prod;
    logic [63:0] rem;
    prod = 64'(x) * 64'(LEHMER_MULT);
    rem  = prod % 64'(LEHMER_MOD);
    return rem[VALUE_W-1:0];
  endfunction

  // seeding pass: warm-up steps, last values fill the table, entry 0 last
  function automatic void load_seed(input logic [VALUE_W-1:0] seed);
    logic [VALUE_W-1:0] x;
    int unsigned        pos;
    x = (seed == '0 || seed == LEHMER_MOD) ? 31'd1 : seed;
    for (int n = 0; n < WARMUP_N; n++) begin
      x   = lehmer_advance(x);
      pos = WARMUP_N - 1 - n;
      if (pos < TABLE_N) shuf_table[pos] = x;
    end
    gen_state  = x;
    shuf_state = shuf_table[0];
  endfunction

  // sample produced by one command, updating the predictor state
  function automatic logic [VALUE_W-1:0] next_sample(input logic cmd,
                                                     input logic [VALUE_W-1:0] seed);
    int unsigned slot;
    if (cmd == CMD_RESEED) load_seed(seed);
    else if (shuf_state == '0) load_seed(31'd1);
    gen_state = lehmer_advance(gen_state);
    slot = shuf_state / SLOT_SPAN;
    if (slot >= TABLE_N) slot = TABLE_N - 1;
    shuf_state       = shuf_table[slot];
    shuf_table[slot] = gen_state;
    return shuf_state;
  endfunction

  // offer one transaction after a random gap, return once it is accepted
  task automatic offer_item(input logic cmd, input logic [VALUE_W-1:0] seed, input int row);
    int             gap;
    int             phase;
    sample_expect_t want;
    phase = items_sent % 150;
    // back-to-back windows, plus a run that keeps offering during the long hold
    if ((phase >= 100 && phase < 130) || (items_sent >= 220 && items_sent < 300)) gap = 0;
    else gap = $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    seed_value <= seed;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transaction taken at this edge
    want.value = next_sample(cmd, seed);
    want.row   = row;
    expected_samples.push_back(want);
    items_sent++;
  endtask

  // stimulus: directed table, random part, then drain and verdict
  initial begin : stimulus
    logic               cmd;
    logic [VALUE_W-1:0] seed;
    int                 pick;
    // first draw after reset seeds with 1, so every reseed to 1 repeats it
    directed[0]  = '{CMD_DRAW,   31'h7FFF_FFFF, NO_TWIN};
    directed[1]  = '{CMD_RESEED, 31'd1,         0};
    // seed 0 and the modulus itself both fall back to 1
    directed[2]  = '{CMD_RESEED, 31'd0,         0};
    directed[3]  = '{CMD_RESEED, 31'h7FFF_FFFF, 0};
    directed[4]  = '{CMD_DRAW,   31'd0,         NO_TWIN};
    directed[5]  = '{CMD_DRAW,   31'h2AAA_AAAA, NO_TWIN};
    directed[6]  = '{CMD_DRAW,   31'h5555_5555, NO_TWIN};
    // largest legal seed
    directed[7]  = '{CMD_RESEED, 31'h7FFF_FFFE, NO_TWIN};
    directed[8]  = '{CMD_DRAW,   31'd0,         NO_TWIN};
    directed[9]  = '{CMD_DRAW,   31'h7FFF_FFFF, NO_TWIN};
    directed[10] = '{CMD_RESEED, 31'd2,         NO_TWIN};
    directed[11] = '{CMD_DRAW,   31'd0,         NO_TWIN};
    directed[12] = '{CMD_RESEED, 31'd2,         10};
    directed[13] = '{CMD_RESEED, 31'h2AAA_AAAA, NO_TWIN};
    directed[14] = '{CMD_RESEED, 31'h5555_5555, NO_TWIN};
    directed[15] = '{CMD_DRAW,   31'd0,         NO_TWIN};
    directed[16] = '{CMD_DRAW,   31'd0,         NO_TWIN};
    directed[17] = '{CMD_RESEED, 31'd1,         0};
    directed[18] = '{CMD_DRAW,   31'd0,         NO_TWIN};
    directed[19] = '{CMD_DRAW,   31'd0,         NO_TWIN};
    directed[20] = '{CMD_DRAW,   31'd0,         NO_TWIN};
    directed[21] = '{CMD_DRAW,   31'd0,         NO_TWIN};
    directed[22] = '{CMD_RESEED, 31'h7FFF_FFFE, 7};
    directed[23] = '{CMD_DRAW,   31'd0,         NO_TWIN};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIRECTED_N; r++)
      offer_item(directed[r].cmd, directed[r].seed, r);

    // mostly draws, with a reseed now and then
    for (int i = 0; i < RANDOM_N; i++) begin
      cmd  = ($urandom_range(0, 11) == 0) ? CMD_RESEED : CMD_DRAW;
      pick = $urandom_range(0, 15);
      case (pick)
        0:       seed = 31'd0;
        1:       seed = 31'h7FFF_FFFF;
        2:       seed = 31'd1;
        3:       seed = 31'h7FFF_FFFE;
        default: seed = VALUE_W'($urandom());
      endcase
      offer_item(cmd, seed, NO_TWIN);
    end
    in_valid <= 1'b0;

    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off, in-order sample check
  initial begin : sample_sink
    int             hold;
    int             taken;
    int             phase;
    sample_expect_t want;
    taken = 0;
    wait (rst == 1'b0);
    forever begin
      phase = taken % 130;
      if (taken == PRESSURE_AT) hold = PRESSURE_HOLD;
      else if (phase >= 60 && phase < 85) hold = 0;
      else hold = $urandom_range(0, 11);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      // transaction taken at this edge
      if (expected_samples.size() == 0) begin
        $error("unexpected sample transaction: sample actual %0d", sample);
        fail_count++;
      end else begin
        want = expected_samples.pop_front();
        if (sample !== want.value) begin
          $error("sample mismatch: expected %0d, actual %0d", want.value, sample);
          fail_count++;
        end
        if (want.row != NO_TWIN) begin
          directed_seen[want.row] = sample;
          // equal effective seeds must give the same first sample
          if (directed[want.row].twin != NO_TWIN &&
              sample !== directed_seen[directed[want.row].twin]) begin
            $error("sample mismatch on reseed repeat: expected %0d, actual %0d",
                   directed_seen[directed[want.row].twin], sample);
            fail_count++;
          end
        end
      end
      taken++;
    end
  end

  // hard stop well past the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: files.f
rtl/core/slrg_pkg.sv
rtl/core/slrg_ram.sv
rtl/core/slrg_datapath.sv
rtl/core/slrg_ctrl.sv
rtl/core/shuffled_lehmer_random_generator.sv
tb/sv/tb_top.sv
